[rtl/deid_pkg.sv]
`default_nettype none

package deid_pkg;

  // Seed constants XORed into the call id words
  localparam logic [63:0] SEED_HIGH_XOR = 64'h4655_4e43_5449_4f4e;
  localparam logic [63:0] SEED_LOW_XOR  = 64'h4558_5041_4e53_494f;

  // FNV-1a 64-bit prime, split as 2^FNV_SHIFT + FNV_LOW
  localparam int unsigned FNV_SHIFT = 40;
  localparam logic [8:0]  FNV_LOW   = 9'd435;

  // Golden-ratio constant for the hash-combine step
  localparam logic [63:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;

  // Version and variant forcing
  localparam logic [63:0] VERSION_MASK = 64'hffff_ffff_ffff_0fff;
  localparam logic [63:0] VERSION_BITS = 64'h0000_0000_0000_5000;
  localparam logic [63:0] VARIANT_MASK = 64'h3fff_ffff_ffff_ffff;
  localparam logic [63:0] VARIANT_BITS = 64'h8000_0000_0000_0000;

  // Input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_ROLE  = 1'b1;

  // Number of source id bytes mixed on a start
  localparam int unsigned SRC_BYTES = 16;
  localparam int unsigned CNT_W     = $clog2(SRC_BYTES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_EMIT
  } state_t;

  // Accumulator pair moved between sequencer and mix unit
  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
  } acc_t;

endpackage

`default_nettype wire

[rtl/deid_mix.sv]
`default_nettype none

// One byte of mixing: FNV-1a into the high word, hash-combine into the low word
module deid_mix (
  input  wire deid_pkg::acc_t acc_in,
  input  wire logic [7:0]     mix_byte,
  output deid_pkg::acc_t      acc_out
);

  logic [63:0] byte_ext;
  logic [63:0] fnv_x;
  logic [63:0] fnv_lo_prod;
  logic [63:0] combine_sum;

  assign byte_ext = {56'd0, mix_byte};

  // FNV-1a: xor the byte in, multiply by the prime as shift plus small product
  assign fnv_x       = acc_in.high ^ byte_ext;
  assign fnv_lo_prod = fnv_x * {55'd0, deid_pkg::FNV_LOW};
  assign acc_out.high = (fnv_x << deid_pkg::FNV_SHIFT) + fnv_lo_prod;

  // Hash-combine with the golden-ratio constant
  assign combine_sum = byte_ext + deid_pkg::GOLDEN + (acc_in.low << 6) + (acc_in.low >> 2);
  assign acc_out.low = acc_in.low ^ combine_sum;

endmodule

`default_nettype wire

[rtl/derived_element_id_hash.sv]
`default_nettype none

// Derived element id: a start request (tuser 0) seeds two 64-bit accumulators
// from the call id and then mixes the 16 source id bytes through one shared
// byte-mix unit, one byte per cycle. A role request (tuser 1) is accepted and
// then mixes its role byte. A request with tlast then loads the output
// register, and waits there while an earlier id has not been taken. A role
// request with no open message is dropped in its accept cycle. The id leaves
// from a registered output, and the input side is not ready while an item is
// being mixed.
module derived_element_id_hash (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // call_high[63:0], call_low[127:64], source_high[191:128],
  // source_low[255:192], role_byte[263:256]
  input  wire logic [263:0] in_tdata,
  // action
  input  wire logic         in_tuser,
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // id_high[63:0], id_low[127:64]
  output logic [127:0]      out_tdata
);

  deid_pkg::state_t state_r, state_nxt;

  logic [deid_pkg::CNT_W-1:0] cnt_r;
  logic                       last_r;
  logic                       open_r;
  logic [127:0]               src_r;
  deid_pkg::acc_t             acc_r;
  deid_pkg::acc_t             acc_mixed;
  logic                       out_valid_r;
  logic [127:0]               out_data_r;

  logic accept;
  logic mix_en;
  logic emit_en;
  logic final_step;

  logic [63:0] call_high;
  logic [63:0] call_low;
  logic [63:0] source_high;
  logic [63:0] source_low;
  logic [7:0]  role_byte;

  assign call_high   = in_tdata[63:0];
  assign call_low    = in_tdata[127:64];
  assign source_high = in_tdata[191:128];
  assign source_low  = in_tdata[255:192];
  assign role_byte   = in_tdata[263:256];

  assign accept     = in_tvalid && in_tready;
  assign final_step = (cnt_r == deid_pkg::CNT_W'(1));

  // Shared byte-mix unit
  deid_mix u_mix (
    .acc_in   (acc_r),
    .mix_byte (src_r[7:0]),
    .acc_out  (acc_mixed)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      deid_pkg::ST_IDLE: begin
        if (accept && (in_tuser == deid_pkg::ACT_START || open_r)) begin
          state_nxt = deid_pkg::ST_MIX;
        end
      end
      deid_pkg::ST_MIX: begin
        if (final_step) begin
          state_nxt = last_r ? deid_pkg::ST_EMIT : deid_pkg::ST_IDLE;
        end
      end
      deid_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = deid_pkg::ST_IDLE;
        end
      end
      default: state_nxt = deid_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    mix_en    = 1'b0;
    emit_en   = 1'b0;
    unique case (state_r)
      deid_pkg::ST_IDLE: in_tready = 1'b1;
      deid_pkg::ST_MIX:  mix_en    = 1'b1;
      deid_pkg::ST_EMIT: emit_en   = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deid_pkg::ST_IDLE;
      cnt_r       <= '0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_tuser == deid_pkg::ACT_START) begin
        cnt_r <= deid_pkg::CNT_W'(deid_pkg::SRC_BYTES);
      end else if (accept && open_r) begin
        cnt_r <= deid_pkg::CNT_W'(1);
      end else if (mix_en) begin
        cnt_r <= cnt_r - deid_pkg::CNT_W'(1);
      end
      // message opens once its mixing is done, closes on emit
      if (mix_en && final_step) begin
        open_r <= 1'b1;
      end else if (emit_en) begin
        open_r <= 1'b0;
      end
      if (emit_en) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: load seeds and bytes, advance mixing, capture the id
  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_tlast;
      if (in_tuser == deid_pkg::ACT_START) begin
        acc_r.high <= call_high ^ deid_pkg::SEED_HIGH_XOR;
        acc_r.low  <= call_low ^ deid_pkg::SEED_LOW_XOR;
        src_r      <= {source_low, source_high};
      end else begin
        src_r <= {120'd0, role_byte};
      end
    end else if (mix_en) begin
      acc_r <= acc_mixed;
      src_r <= src_r >> 8;
    end
    if (emit_en) begin
      out_data_r <= {(acc_r.low & deid_pkg::VARIANT_MASK) | deid_pkg::VARIANT_BITS,
                     (acc_r.high & deid_pkg::VERSION_MASK) | deid_pkg::VERSION_BITS};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
